// File: hdl/tbt_pkg.sv
// Shared constants and types for the touch baseline tracker.
package tbt_pkg;

  localparam int NUM_PINS_DEF   = 16;
  localparam int SKIP_COUNT_DEF = 16;
  localparam int BASELINE_COUNT = 128;
  localparam int BASELINE_SHIFT = $clog2(BASELINE_COUNT);
  localparam int RAW_BITS       = 14;

  localparam int PIN_W      = 4;
  localparam int RAW_W      = 14;
  localparam int DIFF_W     = 15;
  localparam int MASK_W     = 16;
  localparam int THR_W      = 14;
  localparam int SHIFT_W    = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_W      =
    $clog2(BASELINE_COUNT / 2 + BASELINE_COUNT * (2 ** RAW_W - 1) + 1);
  localparam int CALIB_OFFSET = BASELINE_COUNT / 2;

  localparam logic [RAW_W-1:0] RAW_MAX =
    RAW_W'((RAW_BITS >= RAW_W) ? (2 ** RAW_W - 1) : (2 ** RAW_BITS - 1));

  localparam logic [CFG_IDX_W-1:0] REG_PIN_ENABLE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ADAPT_LIMIT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RATE_SHIFT  = CFG_IDX_W'(3);

  localparam logic [MASK_W-1:0]  PIN_ENABLE_RST  = '0;
  localparam logic [THR_W-1:0]   THRESHOLD_RST   = THR_W'(600);
  localparam logic [THR_W-1:0]   ADAPT_LIMIT_RST = THR_W'(200);
  localparam logic [SHIFT_W-1:0] RATE_SHIFT_RST  = SHIFT_W'(6);

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CALIB   = 1'b1;

  typedef logic [RAW_W-1:0]        raw_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic [SUM_W-1:0]        sum_t;

endpackage

// File: hdl/tbt_in_if.sv
// Input channel: one raw sample or calibration sample per beat.
interface tbt_in_if;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [tbt_pkg::PIN_W-1:0] pin;
  tbt_pkg::raw_t            raw_sum;

  modport source (output valid, operation, pin, raw_sum, input ready);
  modport sink   (input valid, operation, pin, raw_sum, output ready);
endinterface

// File: hdl/tbt_out_if.sv
// Result channel: difference, touch flag, baseline and calibration status per beat.
interface tbt_out_if;
  logic           valid;
  logic           ready;
  tbt_pkg::diff_t difference;
  logic           touched;
  tbt_pkg::raw_t  baseline_now;
  logic           calibrating;

  modport source (output valid, difference, touched, baseline_now, calibrating,
                  input ready);
  modport sink   (input valid, difference, touched, baseline_now, calibrating,
                  output ready);
endinterface

// File: hdl/tbt_cfg_if.sv
// Configuration write channel: register index and data per beat.
interface tbt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tbt_pkg::CFG_IDX_W-1:0]  index;
  logic [tbt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/touch_baseline_tracker_top.sv
// Per-pin capacitive touch baseline tracker with calibration averaging.
// Each accepted input beat gives its result beat in the next cycle.
// Throughput: one beat per cycle unless stalled; the per-pin register file is read
// and written in the accept cycle and the result register decouples the output.
// Reset: baselines and counters clear, sums load the rounding offset and
// the configuration registers take their defaults.
module touch_baseline_tracker_top #(
  parameter int NUM_PINS   = tbt_pkg::NUM_PINS_DEF,
  parameter int SKIP_COUNT = tbt_pkg::SKIP_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tbt_in_if.sink     in_ch,
  tbt_out_if.source  out_ch,
  tbt_cfg_if.sink    cfg_ch
);

  localparam int CALIB_TOTAL = SKIP_COUNT + tbt_pkg::BASELINE_COUNT;
  localparam int CNT_W       = $clog2(CALIB_TOTAL + 1);
  localparam int PIX_W       = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam int AVG_W       = tbt_pkg::SUM_W - tbt_pkg::BASELINE_SHIFT;

  logic [tbt_pkg::MASK_W-1:0]  pin_enable_r;
  logic [tbt_pkg::THR_W-1:0]   threshold_r;
  logic [tbt_pkg::THR_W-1:0]   adapt_limit_r;
  logic [tbt_pkg::SHIFT_W-1:0] rate_shift_r;

  tbt_pkg::raw_t base_r [NUM_PINS];
  logic [CNT_W-1:0] cnt_r [NUM_PINS];
  tbt_pkg::sum_t sum_r [NUM_PINS];

  logic          out_valid_r;
  tbt_pkg::diff_t diff_r;
  logic          touched_r;
  tbt_pkg::raw_t baseline_r;
  logic          calibrating_r;

  logic             in_acc;
  logic             pin_ok;
  logic [PIX_W-1:0] idx;
  tbt_pkg::raw_t    base_cur;
  logic [CNT_W-1:0] cnt_cur;
  tbt_pkg::sum_t    sum_cur;
  tbt_pkg::raw_t    raw_sat;
  tbt_pkg::raw_t    raw_eff;
  tbt_pkg::diff_t   diff;
  tbt_pkg::diff_t   diff_neg;
  logic signed [tbt_pkg::DIFF_W:0] diff_ext;
  logic             neg;
  logic             touch_m;
  logic             adapt;
  tbt_pkg::raw_t    mag;
  logic [tbt_pkg::SHIFT_W:0] shamt;
  tbt_pkg::raw_t    step;
  logic signed [tbt_pkg::RAW_W+1:0] adj;
  tbt_pkg::raw_t    adj_sat;
  logic             restart;
  logic [CNT_W-1:0] cnt0;
  logic [CNT_W-1:0] cnt_nxt;
  tbt_pkg::sum_t    sum0;
  tbt_pkg::sum_t    sum_nxt;
  logic             done;
  logic [AVG_W-1:0] avg;
  tbt_pkg::raw_t    avg_sat;
  tbt_pkg::raw_t    base_nxt;
  tbt_pkg::diff_t   diff_nxt;
  logic             touched_nxt;
  logic             calibrating_nxt;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = rst_n && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = rst_n;

  assign pin_ok   = {1'b0, in_ch.pin} < (tbt_pkg::PIN_W + 1)'(NUM_PINS);
  assign idx      = pin_ok ? in_ch.pin[PIX_W-1:0] : '0;
  assign base_cur = base_r[idx];
  assign cnt_cur  = cnt_r[idx];
  assign sum_cur  = sum_r[idx];

  assign raw_sat = (in_ch.raw_sum > tbt_pkg::RAW_MAX) ? tbt_pkg::RAW_MAX : in_ch.raw_sum;
  assign raw_eff = pin_enable_r[in_ch.pin] ? raw_sat : '0;

  // measurement path
  assign diff     = $signed({1'b0, raw_eff}) - $signed({1'b0, base_cur});
  assign diff_neg = -diff;
  assign diff_ext = {diff[tbt_pkg::DIFF_W-1], diff};
  assign neg      = diff[tbt_pkg::DIFF_W-1];
  assign touch_m  = diff_ext > $signed({2'b00, threshold_r});
  assign adapt    = diff_ext < $signed({2'b00, adapt_limit_r});
  assign mag      = neg ? diff_neg[tbt_pkg::RAW_W-1:0] : diff[tbt_pkg::RAW_W-1:0];
  assign shamt    = neg ? {1'b0, rate_shift_r} : ({1'b0, rate_shift_r} + 1'b1);
  assign step     = mag >> shamt;
  assign adj      = neg ? ($signed({2'b00, base_cur}) - $signed({2'b00, step}))
                        : ($signed({2'b00, base_cur}) + $signed({2'b00, step}));
  assign adj_sat  = adj[tbt_pkg::RAW_W+1] ? '0 :
                    (adj > $signed({2'b00, tbt_pkg::RAW_MAX})) ? tbt_pkg::RAW_MAX
                                                               : adj[tbt_pkg::RAW_W-1:0];

  // calibration path
  assign restart = cnt_cur >= CNT_W'(CALIB_TOTAL);
  assign cnt0    = restart ? '0 : cnt_cur;
  assign sum0    = restart ? tbt_pkg::SUM_W'(tbt_pkg::CALIB_OFFSET) : sum_cur;
  assign sum_nxt = (cnt0 >= CNT_W'(SKIP_COUNT)) ? (sum0 + tbt_pkg::SUM_W'(raw_eff)) : sum0;
  assign cnt_nxt = cnt0 + 1'b1;
  assign done    = cnt_nxt == CNT_W'(CALIB_TOTAL);
  assign avg     = sum_nxt[tbt_pkg::SUM_W-1:tbt_pkg::BASELINE_SHIFT];
  assign avg_sat = (avg > AVG_W'(tbt_pkg::RAW_MAX)) ? tbt_pkg::RAW_MAX
                                                   : avg[tbt_pkg::RAW_W-1:0];

  always_comb begin
    base_nxt        = base_cur;
    diff_nxt        = '0;
    touched_nxt     = 1'b0;
    calibrating_nxt = cnt_cur < CNT_W'(CALIB_TOTAL);
    if (in_ch.operation == tbt_pkg::OP_MEASURE) begin
      diff_nxt    = diff;
      touched_nxt = touch_m;
      if (adapt) begin
        base_nxt = adj_sat;
      end
    end else begin
      calibrating_nxt = cnt_nxt < CNT_W'(CALIB_TOTAL);
      if (done) begin
        base_nxt = avg_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_enable_r  <= tbt_pkg::PIN_ENABLE_RST;
      threshold_r   <= tbt_pkg::THRESHOLD_RST;
      adapt_limit_r <= tbt_pkg::ADAPT_LIMIT_RST;
      rate_shift_r  <= tbt_pkg::RATE_SHIFT_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        tbt_pkg::REG_PIN_ENABLE:  pin_enable_r  <= cfg_ch.data[tbt_pkg::MASK_W-1:0];
        tbt_pkg::REG_THRESHOLD:   threshold_r   <= cfg_ch.data[tbt_pkg::THR_W-1:0];
        tbt_pkg::REG_ADAPT_LIMIT: adapt_limit_r <= cfg_ch.data[tbt_pkg::THR_W-1:0];
        tbt_pkg::REG_RATE_SHIFT:  rate_shift_r  <= cfg_ch.data[tbt_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PINS; i++) begin
        base_r[i] <= '0;
        cnt_r[i]  <= '0;
        sum_r[i]  <= tbt_pkg::SUM_W'(tbt_pkg::CALIB_OFFSET);
      end
    end else if (in_acc && pin_ok) begin
      base_r[idx] <= base_nxt;
      if (in_ch.operation == tbt_pkg::OP_CALIB) begin
        cnt_r[idx] <= cnt_nxt;
        sum_r[idx] <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      diff_r        <= pin_ok ? diff_nxt : '0;
      touched_r     <= pin_ok && touched_nxt;
      baseline_r    <= pin_ok ? base_nxt : '0;
      calibrating_r <= pin_ok && calibrating_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.difference   = diff_r;
  assign out_ch.touched      = touched_r;
  assign out_ch.baseline_now = baseline_r;
  assign out_ch.calibrating  = calibrating_r;

endmodule

// File: hdl/tbt_checker.sv
// Port-level assertions for the touch baseline tracker and their binding.
module tbt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_operation,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tbt_pkg::DIFF_W-1:0]  out_difference,
  input logic                        out_touched
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_calib_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == tbt_pkg::OP_CALIB
      |=> out_difference == '0 && !out_touched)
    else $error("calibration beat reported a difference or touch");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind touch_baseline_tracker_top tbt_checker u_tbt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_operation   (in_ch.operation),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_difference (out_ch.difference),
  .out_touched    (out_ch.touched)
);
